// ----- hw/rtl/pect_pkg.sv -----
// shared types and constants for the ear clipping triangulator
// no dependencies
`timescale 1ns / 1ps

package pect_pkg;

    localparam int MAX_VERTS_DEF = 64;
    localparam int COORD_W_DEF   = 24;
    localparam int NORM_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CORNER_W      = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X = 2'd0,
        CFG_NORMAL_Y = 2'd1,
        CFG_NORMAL_Z = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MUL_AREA,
        MUL_CONVEX,
        MUL_SIDE1,
        MUL_SIDE2,
        MUL_SIDE3
    } t_mul_op;

    typedef enum logic [2:0] {
        PSEL_CNT,
        PSEL_A,
        PSEL_B,
        PSEL_C,
        PSEL_P
    } t_psel;

    typedef enum logic [2:0] {
        LAT_NONE,
        LAT_A,
        LAT_B,
        LAT_C,
        LAT_P
    } t_lat;

    typedef struct packed {
        logic    vtx_we;
        t_psel   psel;
        t_lat    pt_lat;
        t_lat    idx_lat;
        logic    mul_en;
        t_mul_op mul_op;
        logic    area_clr;
        logic    area_acc;
        logic    flag_clr;
        logic    flag_acc;
        logic    lst_we;
        logic    lst_wsel;
        logic    out_load;
        logic    out_fan;
        logic    out_ovf;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        logic ccw;
        logic dom_pos;
        logic det_neg;
        logic in_tri;
        logic same_pt;
    } t_sts;

    typedef enum logic [5:0] {
        S_IDLE, S_START,
        S_AR0, S_AR1, S_AR2, S_AR3, S_AR4, S_DIR,
        S_INIT, S_SCAN,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_ENEXT,
        S_K0, S_K1, S_K2, S_K3, S_K4, S_K5, S_K6, S_K7, S_K8,
        S_CLIP, S_EOUT, S_MV0, S_MV1,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_FOUT,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/pect_vtx_if.sv -----
// vertex request channel: valid, ready and one 3d point
// depends on pect_pkg
`timescale 1ns / 1ps

interface pect_vtx_if #(
    parameter int COORD_WIDTH = pect_pkg::COORD_W_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          final_vertex;

    modport source (output valid, coord_x, coord_y, coord_z, final_vertex, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, final_vertex, output ready);
endinterface

// ----- hw/rtl/pect_tri_if.sv -----
// triangle request channel: valid, ready and one index triple with flags
// depends on pect_pkg
`timescale 1ns / 1ps

interface pect_tri_if;
    logic                            valid;
    logic                            ready;
    logic [pect_pkg::CORNER_W-1:0]   corner_a;
    logic [pect_pkg::CORNER_W-1:0]   corner_b;
    logic [pect_pkg::CORNER_W-1:0]   corner_c;
    logic                            fan_used;
    logic                            overflow;
    logic                            last_triangle;

    modport source (output valid, corner_a, corner_b, corner_c, fan_used, overflow,
                    last_triangle, input ready);
    modport sink   (input valid, corner_a, corner_b, corner_c, fan_used, overflow,
                    last_triangle, output ready);
endinterface

// ----- hw/rtl/pect_datapath.sv -----
// datapath: normal registers, vertex and live list memories, shared
// cross product unit, area accumulator and result register; uses pect_pkg
`timescale 1ns / 1ps

module pect_datapath #(
    parameter int MAX_VERTS   = pect_pkg::MAX_VERTS_DEF,
    parameter int COORD_WIDTH = pect_pkg::COORD_W_DEF,
    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pect_pkg::t_cmd                      i_cmd,
    input  logic [IW-1:0]                       i_proj_addr,
    input  logic [IW-1:0]                       i_lst_raddr,
    input  logic [IW-1:0]                       i_lst_waddr,
    input  logic [IW-1:0]                       i_lst_wdata,
    input  logic                                i_cfg_we,
    input  logic [pect_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pect_pkg::NORM_W-1:0]         i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]       i_coord_z,
    output pect_pkg::t_sts                      o_sts,
    output logic [pect_pkg::CORNER_W-1:0]       o_corner_a,
    output logic [pect_pkg::CORNER_W-1:0]       o_corner_b,
    output logic [pect_pkg::CORNER_W-1:0]       o_corner_c,
    output logic                                o_fan_used,
    output logic                                o_overflow,
    output logic                                o_last_triangle
);
    import pect_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int AW = PW + 1 + $clog2(MAX_VERTS) + 1;

    logic signed [NORM_W-1:0] r_nx, r_ny, r_nz;
    logic [NORM_W:0]          w_ax, w_ay, w_az;
    logic [1:0]               w_axis;
    logic                     w_dom_pos;

    logic signed [COORD_WIDTH-1:0] mem_u [MAX_VERTS];
    logic signed [COORD_WIDTH-1:0] mem_v [MAX_VERTS];
    logic [IW-1:0]                 mem_l [MAX_VERTS];

    logic signed [COORD_WIDTH-1:0] r_ru, r_rv;
    logic [IW-1:0]                 r_lrd;
    logic [IW-1:0]                 w_paddr;
    logic signed [COORD_WIDTH-1:0] w_wu, w_wv;

    logic signed [COORD_WIDTH-1:0] r_au, r_av, r_bu, r_bv, r_cu, r_cv, r_pu, r_pv;
    logic [IW-1:0]                 r_ia, r_ib, r_ic, r_ip;

    logic signed [DW-1:0] w_x1, w_y1, w_x2, w_y2;
    logic signed [PW-1:0] r_m1, r_m2;
    logic signed [PW:0]   w_det;
    logic                 w_det_pos;
    logic signed [AW-1:0] r_area;
    logic                 r_hn, r_hp;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NORMAL_X: r_nx <= i_cfg_data;
                CFG_NORMAL_Y: r_ny <= i_cfg_data;
                CFG_NORMAL_Z: r_nz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dominant axis of the normal
    always_comb begin
        w_ax = r_nx[NORM_W-1] ? -{r_nx[NORM_W-1], r_nx} : {r_nx[NORM_W-1], r_nx};
        w_ay = r_ny[NORM_W-1] ? -{r_ny[NORM_W-1], r_ny} : {r_ny[NORM_W-1], r_ny};
        w_az = r_nz[NORM_W-1] ? -{r_nz[NORM_W-1], r_nz} : {r_nz[NORM_W-1], r_nz};
        if (w_ax >= w_ay && w_ax >= w_az) begin
            w_axis = 2'd0;
        end else if (w_ay >= w_az) begin
            w_axis = 2'd1;
        end else begin
            w_axis = 2'd2;
        end
        case (w_axis)
            2'd0:    w_dom_pos = (r_nx > 0);
            2'd1:    w_dom_pos = (r_ny > 0);
            default: w_dom_pos = (r_nz > 0);
        endcase
        w_wu = (w_axis == 2'd0) ? i_coord_y : i_coord_x;
        w_wv = (w_axis == 2'd2) ? i_coord_y : i_coord_z;
    end

    always_comb begin
        case (i_cmd.psel)
            PSEL_A:  w_paddr = r_ia;
            PSEL_B:  w_paddr = r_ib;
            PSEL_C:  w_paddr = r_ic;
            PSEL_P:  w_paddr = r_ip;
            default: w_paddr = i_proj_addr;
        endcase
    end

    // projected vertex memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_we) begin
            mem_u[i_proj_addr] <= w_wu;
            mem_v[i_proj_addr] <= w_wv;
        end
        r_ru <= mem_u[w_paddr];
        r_rv <= mem_v[w_paddr];
    end

    // live list memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.lst_we) begin
            mem_l[i_lst_waddr] <= i_cmd.lst_wsel ? r_lrd : i_lst_wdata;
        end
        r_lrd <= mem_l[i_lst_raddr];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.pt_lat)
            LAT_A: begin
                r_au <= r_ru;
                r_av <= r_rv;
            end
            LAT_B: begin
                r_bu <= r_ru;
                r_bv <= r_rv;
            end
            LAT_C: begin
                r_cu <= r_ru;
                r_cv <= r_rv;
            end
            LAT_P: begin
                r_pu <= r_ru;
                r_pv <= r_rv;
            end
            default: ;
        endcase
        case (i_cmd.idx_lat)
            LAT_A:   r_ia <= r_lrd;
            LAT_B:   r_ib <= r_lrd;
            LAT_C:   r_ic <= r_lrd;
            LAT_P:   r_ip <= r_lrd;
            default: ;
        endcase
    end

    // operand select for the shared cross product
    always_comb begin
        case (i_cmd.mul_op)
            MUL_AREA: begin
                w_x1 = DW'(r_au);
                w_y1 = DW'(r_bv);
                w_x2 = DW'(r_bu);
                w_y2 = DW'(r_av);
            end
            MUL_CONVEX: begin
                w_x1 = DW'(r_bu) - DW'(r_au);
                w_y1 = DW'(r_cv) - DW'(r_bv);
                w_x2 = DW'(r_bv) - DW'(r_av);
                w_y2 = DW'(r_cu) - DW'(r_bu);
            end
            MUL_SIDE1: begin
                w_x1 = DW'(r_pu) - DW'(r_bu);
                w_y1 = DW'(r_av) - DW'(r_bv);
                w_x2 = DW'(r_au) - DW'(r_bu);
                w_y2 = DW'(r_pv) - DW'(r_bv);
            end
            MUL_SIDE2: begin
                w_x1 = DW'(r_pu) - DW'(r_cu);
                w_y1 = DW'(r_bv) - DW'(r_cv);
                w_x2 = DW'(r_bu) - DW'(r_cu);
                w_y2 = DW'(r_pv) - DW'(r_cv);
            end
            default: begin
                w_x1 = DW'(r_pu) - DW'(r_au);
                w_y1 = DW'(r_cv) - DW'(r_av);
                w_x2 = DW'(r_cu) - DW'(r_au);
                w_y2 = DW'(r_pv) - DW'(r_av);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_m1 <= w_x1 * w_y1;
            r_m2 <= w_x2 * w_y2;
        end
    end

    assign w_det     = (PW+1)'(r_m1) - (PW+1)'(r_m2);
    assign w_det_pos = !w_det[PW] && (w_det != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.area_clr) begin
            r_area <= '0;
        end else if (i_cmd.area_acc) begin
            r_area <= r_area + AW'(w_det);
        end
        if (i_cmd.flag_clr) begin
            r_hn <= 1'b0;
            r_hp <= 1'b0;
        end else if (i_cmd.flag_acc) begin
            r_hn <= r_hn | w_det[PW];
            r_hp <= r_hp | w_det_pos;
        end
    end

    assign o_sts.ccw     = (r_area > 0);
    assign o_sts.dom_pos = w_dom_pos;
    assign o_sts.det_neg = w_det[PW];
    assign o_sts.in_tri  = !(r_hn && r_hp);
    assign o_sts.same_pt = (r_pu == r_au && r_pv == r_av) ||
                           (r_pu == r_bu && r_pv == r_bv) ||
                           (r_pu == r_cu && r_pv == r_cv);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_corner_a      <= CORNER_W'(r_ia);
            o_corner_b      <= CORNER_W'(r_ib);
            o_corner_c      <= CORNER_W'(r_ic);
            o_fan_used      <= i_cmd.out_fan;
            o_overflow      <= i_cmd.out_ovf;
            o_last_triangle <= i_cmd.out_last;
        end
    end

endmodule

// ----- hw/rtl/pect_ctrl.sv -----
// controller: load, winding, list setup, ear search, clip and fan sequencer
// uses pect_pkg; drives pect_datapath through t_cmd
`timescale 1ns / 1ps

module pect_ctrl #(
    parameter int MAX_VERTS = pect_pkg::MAX_VERTS_DEF,
    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1,
    localparam int CW = $clog2(MAX_VERTS + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_final,
    input  logic            i_out_ready,
    input  pect_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output pect_pkg::t_cmd  o_cmd,
    output logic [IW-1:0]   o_proj_addr,
    output logic [IW-1:0]   o_lst_raddr,
    output logic [IW-1:0]   o_lst_waddr,
    output logic [IW-1:0]   o_lst_wdata
);
    import pect_pkg::*;

    t_state r_state, n_state;
    logic [CW-1:0] r_vcnt, n_vcnt, r_n, n_n, r_m, n_m, r_i, n_i, r_k, n_k;
    logic          r_ovf, n_ovf, r_rev, n_rev;
    logic [CW-1:0] w_ip, w_in, w_i1, w_rinit;
    logic          w_i1_end, w_i2_end, w_i1_ge;

    function automatic logic [IW-1:0] n_k_plus(input logic [CW-1:0] k);
        logic [CW-1:0] s;
        s = k + 1'b1;
        return s[IW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_ovf   <= 1'b0;
            r_n     <= '0;
            r_m     <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vcnt  <= n_vcnt;
            r_ovf   <= n_ovf;
            r_n     <= n_n;
            r_m     <= n_m;
            r_i     <= n_i;
            r_k     <= n_k;
            r_rev   <= n_rev;
        end
    end

    assign w_i1     = r_i + 1'b1;
    assign w_i1_end = ({1'b0, r_i} + (CW+1)'(1)) == {1'b0, r_m};
    assign w_i1_ge  = ({1'b0, r_i} + (CW+1)'(1)) >= {1'b0, r_m};
    assign w_i2_end = ({1'b0, r_i} + (CW+1)'(2)) == {1'b0, r_m};
    assign w_ip     = (r_i == '0) ? r_m - 1'b1 : r_i - 1'b1;
    assign w_in     = w_i1_end ? '0 : w_i1;
    assign w_rinit  = r_rev ? r_n - 1'b1 - r_i : r_i;

    always_comb begin
        n_state = r_state;
        n_vcnt  = r_vcnt;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_m     = r_m;
        n_i     = r_i;
        n_k     = r_k;
        n_rev   = r_rev;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.psel  = PSEL_CNT;
        o_cmd.pt_lat  = LAT_NONE;
        o_cmd.idx_lat = LAT_NONE;
        o_cmd.mul_op  = MUL_AREA;
        o_cmd.out_ovf = r_ovf;
        o_proj_addr = r_i[IW-1:0];
        o_lst_raddr = r_i[IW-1:0];
        o_lst_waddr = r_i[IW-1:0];
        o_lst_wdata = w_rinit[IW-1:0];

        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_proj_addr = r_vcnt[IW-1:0];
                if (i_in_valid) begin
                    if (r_vcnt < CW'(MAX_VERTS)) begin
                        o_cmd.vtx_we = 1'b1;
                        n_vcnt = r_vcnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_final) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_n = r_vcnt;
                n_i = '0;
                o_cmd.area_clr = 1'b1;
                if (r_vcnt < CW'(3)) begin
                    n_state = S_DONE;
                end else if (r_vcnt == CW'(3)) begin
                    n_rev   = 1'b0;
                    n_state = S_INIT;
                end else begin
                    n_state = S_AR0;
                end
            end
            // shoelace area
            S_AR0: begin
                n_state = S_AR1;
            end
            S_AR1: begin
                o_cmd.pt_lat = LAT_A;
                o_proj_addr  = (w_i1 == r_n) ? '0 : w_i1[IW-1:0];
                n_state = S_AR2;
            end
            S_AR2: begin
                o_cmd.pt_lat = LAT_B;
                n_state = S_AR3;
            end
            S_AR3: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_AREA;
                n_state = S_AR4;
            end
            S_AR4: begin
                o_cmd.area_acc = 1'b1;
                if (w_i1 == r_n) begin
                    n_state = S_DIR;
                end else begin
                    n_i     = w_i1;
                    n_state = S_AR0;
                end
            end
            S_DIR: begin
                n_rev   = i_sts.ccw != i_sts.dom_pos;
                n_i     = '0;
                n_state = S_INIT;
            end
            S_INIT: begin
                o_cmd.lst_we = 1'b1;
                if (w_i1 == r_n) begin
                    n_m     = r_n;
                    n_state = S_SCAN;
                end else begin
                    n_i = w_i1;
                end
            end
            S_SCAN: begin
                if (r_m > CW'(3)) begin
                    n_i     = '0;
                    n_state = S_E0;
                end else begin
                    n_i     = CW'(1);
                    n_state = S_F0;
                end
            end
            // ear candidate fetch and convexity test
            S_E0: begin
                o_lst_raddr = w_ip[IW-1:0];
                n_state = S_E1;
            end
            S_E1: begin
                o_cmd.idx_lat = LAT_A;
                n_state = S_E2;
            end
            S_E2: begin
                o_cmd.idx_lat = LAT_B;
                o_lst_raddr = w_in[IW-1:0];
                n_state = S_E3;
            end
            S_E3: begin
                o_cmd.idx_lat = LAT_C;
                o_cmd.psel = PSEL_A;
                n_state = S_E4;
            end
            S_E4: begin
                o_cmd.pt_lat = LAT_A;
                o_cmd.psel = PSEL_B;
                n_state = S_E5;
            end
            S_E5: begin
                o_cmd.pt_lat = LAT_B;
                o_cmd.psel = PSEL_C;
                n_state = S_E6;
            end
            S_E6: begin
                o_cmd.pt_lat = LAT_C;
                n_state = S_E7;
            end
            S_E7: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = MUL_CONVEX;
                n_state = S_E8;
            end
            S_E8: begin
                if (i_sts.det_neg) begin
                    n_state = S_ENEXT;
                end else begin
                    n_k     = '0;
                    n_state = S_K0;
                end
            end
            S_ENEXT: begin
                if (w_i1_end) begin
                    n_i     = CW'(1);
                    n_state = S_F0;
                end else begin
                    n_i     = w_i1;
                    n_state = S_E0;
                end
            end
            // containment test over live vertices
            S_K0: begin
                o_lst_raddr = r_k[IW-1:0];
                if (r_k == r_m) begin
                    n_state = S_CLIP;
                end else if (r_k == w_ip || r_k == r_i || r_k == w_in) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_state = S_K1;
                end
            end
            S_K1: begin
                o_cmd.idx_lat = LAT_P;
                n_state = S_K2;
            end
            S_K2: begin
                o_cmd.psel = PSEL_P;
                n_state = S_K3;
            end
            S_K3: begin
                o_cmd.pt_lat = LAT_P;
                n_state = S_K4;
            end
            S_K4: begin
                if (i_sts.same_pt) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_K0;
                end else begin
                    o_cmd.flag_clr = 1'b1;
                    o_cmd.mul_en   = 1'b1;
                    o_cmd.mul_op   = MUL_SIDE1;
                    n_state = S_K5;
                end
            end
            S_K5: begin
                o_cmd.flag_acc = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_op   = MUL_SIDE2;
                n_state = S_K6;
            end
            S_K6: begin
                o_cmd.flag_acc = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_op   = MUL_SIDE3;
                n_state = S_K7;
            end
            S_K7: begin
                o_cmd.flag_acc = 1'b1;
                n_state = S_K8;
            end
            S_K8: begin
                if (i_sts.in_tri) begin
                    n_state = S_ENEXT;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_K0;
                end
            end
            // emit ear, then close the gap in the live list
            S_CLIP: begin
                o_cmd.out_load = 1'b1;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_k     = r_i;
                    n_state = S_MV0;
                end
            end
            S_MV0: begin
                o_lst_raddr = n_k_plus(r_k);
                if (({1'b0, r_k} + (CW+1)'(1)) >= {1'b0, r_m}) begin
                    n_m     = r_m - 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_MV1;
                end
            end
            S_MV1: begin
                o_cmd.lst_we   = 1'b1;
                o_cmd.lst_wsel = 1'b1;
                o_lst_waddr    = r_k[IW-1:0];
                n_k     = r_k + 1'b1;
                n_state = S_MV0;
            end
            // final triangle or fan
            S_F0: begin
                o_lst_raddr = '0;
                n_state = w_i1_ge ? S_DONE : S_F1;
            end
            S_F1: begin
                o_cmd.idx_lat = LAT_A;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.idx_lat = LAT_B;
                o_lst_raddr = w_i1[IW-1:0];
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.idx_lat = LAT_C;
                n_state = S_F4;
            end
            S_F4: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_fan  = (r_m != CW'(3));
                o_cmd.out_last = w_i2_end;
                n_state = S_FOUT;
            end
            S_FOUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_i     = w_i1;
                    n_state = S_F0;
                end
            end
            S_DONE: begin
                n_vcnt  = '0;
                n_ovf   = 1'b0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/polygon_ear_clip_triangulator_unit.sv -----
// polygon ear clip triangulator: vertex load, winding, ear clipping, fan fallback
// a vertex that does not end the polygon is accepted in the idle state; the final vertex starts a run
// of area terms, ear candidates and containment tests, taken one after another
// through the single shared cross product unit, plus the wait on each triangle request
// reset clears the normal registers, the vertex count, the overflow flag and the sequencer
`timescale 1ns / 1ps

module polygon_ear_clip_triangulator_unit #(
    parameter int MAX_VERTS   = pect_pkg::MAX_VERTS_DEF,
    parameter int COORD_WIDTH = pect_pkg::COORD_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pect_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pect_pkg::NORM_W-1:0]       i_cfg_data,
    pect_vtx_if.sink                          i_vtx,
    pect_tri_if.source                        o_tri
);
    import pect_pkg::*;

    localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_proj_addr, w_lst_raddr, w_lst_waddr, w_lst_wdata;
    logic          w_in_ready, w_out_valid;

    pect_ctrl #(
        .MAX_VERTS (MAX_VERTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .i_in_final  (i_vtx.final_vertex),
        .i_out_ready (o_tri.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd),
        .o_proj_addr (w_proj_addr),
        .o_lst_raddr (w_lst_raddr),
        .o_lst_waddr (w_lst_waddr),
        .o_lst_wdata (w_lst_wdata)
    );

    pect_datapath #(
        .MAX_VERTS   (MAX_VERTS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_proj_addr     (w_proj_addr),
        .i_lst_raddr     (w_lst_raddr),
        .i_lst_waddr     (w_lst_waddr),
        .i_lst_wdata     (w_lst_wdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_coord_x       (i_vtx.coord_x),
        .i_coord_y       (i_vtx.coord_y),
        .i_coord_z       (i_vtx.coord_z),
        .o_sts           (w_sts),
        .o_corner_a      (o_tri.corner_a),
        .o_corner_b      (o_tri.corner_b),
        .o_corner_c      (o_tri.corner_c),
        .o_fan_used      (o_tri.fan_used),
        .o_overflow      (o_tri.overflow),
        .o_last_triangle (o_tri.last_triangle)
    );

    assign i_vtx.ready = w_in_ready;
    assign o_tri.valid = w_out_valid;

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_in_ready && w_out_valid))
        else $error("vertex load open while a triangle is pending");

    a_store_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.vtx_we |-> (i_vtx.valid && w_in_ready))
        else $error("vertex stored without an accepted request");

    a_result_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> w_out_valid)
        else $error("result loaded but not presented");

endmodule

// ----- sim/tb_polygon_ear_clip_triangulator_unit.sv -----
// testbench for polygon_ear_clip_triangulator_unit: vertex requests in, triangle requests out
// predicts triangles with an exact integer ear clipper; depends on pect_pkg and both interfaces
`timescale 1ns / 1ps

module tb_polygon_ear_clip_triangulator_unit;
    import pect_pkg::*;

    typedef struct {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        bit                 fin;
    } vertex_t;

    typedef struct {
        bit [5:0] a;
        bit [5:0] b;
        bit [5:0] c;
        bit       fan;
        bit       ovf;
        bit       last;
    } triangle_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [NORM_W-1:0] i_cfg_data = '0;

    pect_vtx_if vtx_ch ();
    pect_tri_if tri_ch ();

    polygon_ear_clip_triangulator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vtx      (vtx_ch),
        .o_tri      (tri_ch)
    );

    always #5 i_clk = ~i_clk;

    vertex_t   vtx_pending[$];
    triangle_t tri_expect[$];
    vertex_t   cur_vtx;
    int        vtx_queued = 0;
    int        vtx_accepted = 0;
    int        tri_checked = 0;
    int        fan_seen = 0;
    int        ovf_seen_cnt = 0;
    int        polys_queued = 0;
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;

    // mirror of the block state
    logic signed [15:0] nrm_x = '0, nrm_y = '0, nrm_z = '0;
    longint pu[64];
    longint pv[64];
    int     live[64];
    int     vcount = 0;
    bit     ovf_flag = 1'b0;

    function automatic int dom_axis(logic signed [15:0] nx, logic signed [15:0] ny,
                                    logic signed [15:0] nz);
        longint ax, ay, az;
        ax = nx < 0 ? -longint'(nx) : longint'(nx);
        ay = ny < 0 ? -longint'(ny) : longint'(ny);
        az = nz < 0 ? -longint'(nz) : longint'(nz);
        if (ax >= ay && ax >= az) return 0;
        if (ay >= az) return 1;
        return 2;
    endfunction

    function automatic int det_sign(longint a, longint b, longint c, longint d);
        longint p;
        p = a * b - c * d;
        return p > 0 ? 1 : (p < 0 ? -1 : 0);
    endfunction

    function automatic int side(int p1, int p2, int p3);
        return det_sign(pu[p1] - pu[p3], pv[p2] - pv[p3], pu[p2] - pu[p3], pv[p1] - pv[p3]);
    endfunction

    function automatic bit in_or_on(int p, int a, int b, int c);
        int d1, d2, d3;
        d1 = side(p, a, b);
        d2 = side(p, b, c);
        d3 = side(p, c, a);
        return !((d1 < 0 || d2 < 0 || d3 < 0) && (d1 > 0 || d2 > 0 || d3 > 0));
    endfunction

    function automatic bit coincide(int a, int b);
        return pu[a] == pu[b] && pv[a] == pv[b];
    endfunction

    function automatic bit ear_at(int m, int ip, int ic, int inx);
        int a, b, c, p;
        a = live[ip];
        b = live[ic];
        c = live[inx];
        if (det_sign(pu[b] - pu[a], pv[c] - pv[b], pv[b] - pv[a], pu[c] - pu[b]) < 0)
            return 1'b0;
        for (int k = 0; k < m; k++) begin
            if (k == ip || k == ic || k == inx) continue;
            p = live[k];
            if (coincide(p, a) || coincide(p, b) || coincide(p, c)) continue;
            if (in_or_on(p, a, b, c)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic triangle_t mk_tri(int a, int b, int c, bit fan);
        triangle_t t;
        t.a = a[5:0];
        t.b = b[5:0];
        t.c = c[5:0];
        t.fan = fan;
        t.ovf = ovf_flag;
        t.last = 1'b0;
        return t;
    endfunction

    function automatic void clip_polygon();
        triangle_t res[$];
        int n, m, ip, inx, axis;
        bit pos, ccw, rev, found;
        longint area;
        n = vcount;
        area = 0;
        if (n < 3) return;
        if (n == 3) begin
            res.insert(res.size(), mk_tri(0, 1, 2, 1'b0));
        end else begin
            axis = dom_axis(nrm_x, nrm_y, nrm_z);
            pos = axis == 0 ? nrm_x > 0 : (axis == 1 ? nrm_y > 0 : nrm_z > 0);
            for (int i = 0; i < n; i++) begin
                int j;
                j = (i + 1 == n) ? 0 : i + 1;
                area += pu[i] * pv[j] - pu[j] * pv[i];
            end
            ccw = area > 0;
            rev = ccw != pos;
            for (int i = 0; i < n; i++) live[i] = rev ? n - 1 - i : i;
            m = n;
            while (m > 3) begin
                found = 1'b0;
                for (int i = 0; i < m; i++) begin
                    ip = (i == 0) ? m - 1 : i - 1;
                    inx = (i + 1 == m) ? 0 : i + 1;
                    if (ear_at(m, ip, i, inx)) begin
                        res.insert(res.size(), mk_tri(live[ip], live[i], live[inx], 1'b0));
                        for (int j = i; j < m - 1; j++) live[j] = live[j + 1];
                        m--;
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) break;
            end
            if (m == 3) begin
                res.insert(res.size(), mk_tri(live[0], live[1], live[2], 1'b0));
            end else begin
                for (int i = 1; i + 1 < m; i++)
                    res.insert(res.size(), mk_tri(live[0], live[i], live[i + 1], 1'b1));
            end
        end
        res[res.size() - 1].last = 1'b1;
        foreach (res[i]) tri_expect.insert(tri_expect.size(), res[i]);
    endfunction

    function automatic void take_vertex(vertex_t v);
        int axis;
        if (vcount < 64) begin
            axis = dom_axis(nrm_x, nrm_y, nrm_z);
            pu[vcount] = axis == 0 ? longint'(v.y) : longint'(v.x);
            pv[vcount] = axis == 2 ? longint'(v.y) : longint'(v.z);
            vcount++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (v.fin) begin
            clip_polygon();
            vcount = 0;
            ovf_flag = 1'b0;
        end
    endfunction

    // vertex driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vtx_ch.valid <= 1'b0;
        end else begin
            if (vtx_ch.valid && vtx_ch.ready) begin
                take_vertex(cur_vtx);
                vtx_accepted++;
            end
            if (!vtx_ch.valid || vtx_ch.ready) begin
                if (vtx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_vtx = vtx_pending.pop_front();
                    vtx_ch.coord_x <= cur_vtx.x;
                    vtx_ch.coord_y <= cur_vtx.y;
                    vtx_ch.coord_z <= cur_vtx.z;
                    vtx_ch.final_vertex <= cur_vtx.fin;
                    vtx_ch.valid <= 1'b1;
                end else begin
                    vtx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // triangle monitor
    always @(posedge i_clk) begin
        triangle_t exp_t;
        if (!i_rst_n) begin
            tri_ch.ready <= 1'b0;
        end else begin
            if (tri_ch.valid && tri_ch.ready) begin
                if (tri_expect.size() == 0) begin
                    $display("%0t: unexpected triangle %0d %0d %0d", $time,
                             tri_ch.corner_a, tri_ch.corner_b, tri_ch.corner_c);
                    errors++;
                end else begin
                    exp_t = tri_expect.pop_front();
                    tri_checked++;
                    if (exp_t.fan) fan_seen++;
                    if (exp_t.ovf) ovf_seen_cnt++;
                    if ({tri_ch.corner_a, tri_ch.corner_b, tri_ch.corner_c, tri_ch.fan_used,
                         tri_ch.overflow, tri_ch.last_triangle} !==
                        {exp_t.a, exp_t.b, exp_t.c, exp_t.fan, exp_t.ovf, exp_t.last}) begin
                        $display("%0t: mismatch expected %0d %0d %0d fan %0d ovf %0d last %0d",
                                 $time, exp_t.a, exp_t.b, exp_t.c, exp_t.fan, exp_t.ovf,
                                 exp_t.last);
                        $display("%0t:          actual %0d %0d %0d fan %0d ovf %0d last %0d",
                                 $time, tri_ch.corner_a, tri_ch.corner_b, tri_ch.corner_c,
                                 tri_ch.fan_used, tri_ch.overflow, tri_ch.last_triangle);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_left <= 3000;
                hold_done <= 1'b1;
                tri_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                tri_ch.ready <= 1'b0;
            end else begin
                tri_ch.ready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    task automatic push_vtx(int x, int y, int z, bit fin);
        vertex_t v;
        v.x = x[23:0];
        v.y = y[23:0];
        v.z = z[23:0];
        v.fin = fin;
        vtx_pending.insert(vtx_pending.size(), v);
        vtx_queued++;
        if (fin) polys_queued++;
    endtask

    // place a projected point (u,v) on the plane kept by the current normal
    task automatic push_uv(int u, int v, int w, bit fin);
        case (dom_axis(nrm_x, nrm_y, nrm_z))
            0: push_vtx(w, u, v, fin);
            1: push_vtx(u, w, v, fin);
            default: push_vtx(u, v, w, fin);
        endcase
    endtask

    task automatic wait_idle();
        while (vtx_accepted != vtx_queued || tri_expect.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic set_normal(int nx, int ny, int nz);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_NORMAL_X;
        i_cfg_data <= nx[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_NORMAL_Y;
        i_cfg_data <= ny[15:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_NORMAL_Z;
        i_cfg_data <= nz[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        nrm_x = nx[15:0];
        nrm_y = ny[15:0];
        nrm_z = nz[15:0];
    endtask

    function automatic int pick_norm();
        case ($urandom_range(5))
            0: return 32767;
            1: return -32768;
            2: return 0;
            3: return -32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic star_polygon(int n, int radius);
        int cu, cv, u, v;
        real ang, r;
        bit flip;
        cu = int'($urandom_range(8388607)) - 4194304;
        cv = int'($urandom_range(8388607)) - 4194304;
        flip = $urandom_range(1);
        for (int i = 0; i < n; i++) begin
            ang = 6.283185307 * (i + $urandom_range(900) / 1000.0) / n;
            if (flip) ang = -ang;
            r = radius * (0.3 + $urandom_range(700) / 1000.0);
            u = cu + $rtoi(r * $cos(ang));
            v = cv + $rtoi(r * $sin(ang));
            push_uv(u, v, int'($urandom()), i == n - 1);
        end
    endtask

    task automatic noise_polygon(int n);
        for (int i = 0; i < n; i++)
            push_vtx(int'($urandom()), int'($urandom()), int'($urandom()), i == n - 1);
    endtask

    task automatic random_polygon();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        if ($urandom_range(9) < 7) star_polygon(n, $urandom_range(16, 2097152));
        else noise_polygon(n);
    endtask

    initial begin
        int phase;
        vtx_ch.valid = 1'b0;
        vtx_ch.coord_x = '0;
        vtx_ch.coord_y = '0;
        vtx_ch.coord_z = '0;
        vtx_ch.final_vertex = 1'b0;
        tri_ch.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset normal, plain triangle, then polygons too short to emit
        push_vtx(0, 0, 0, 0);
        push_vtx(4096, 0, 0, 0);
        push_vtx(0, 4096, 0, 1);
        push_vtx(100, 200, 300, 1);
        push_vtx(-5, 7, 9, 0);
        push_vtx(11, -13, 17, 1);
        // clockwise square against a +z normal: reversed order
        set_normal(0, 0, 32767);
        push_vtx(0, 0, 5, 0);
        push_vtx(0, 4096, 5, 0);
        push_vtx(4096, 4096, 5, 0);
        push_vtx(4096, 0, 5, 1);
        // concave l shape against a -z normal
        set_normal(0, 0, -32768);
        push_vtx(0, 0, 0, 0);
        push_vtx(8192, 0, 0, 0);
        push_vtx(8192, 4096, 0, 0);
        push_vtx(4096, 4096, 0, 0);
        push_vtx(4096, 8192, 0, 0);
        push_vtx(0, 8192, 0, 1);
        // collinear points: no ear, fan fallback
        set_normal(32767, 0, 0);
        push_vtx(-8388608, 0, 0, 0);
        push_vtx(8388607, 4096, 4096, 0);
        push_vtx(0, 8192, 8192, 0);
        push_vtx(77, 12288, 12288, 1);
        // coincident vertex and coordinate extremes, y dominant
        set_normal(0, -32768, 0);
        push_vtx(-8388608, 8388607, -8388608, 0);
        push_vtx(8388607, -8388608, -8388608, 0);
        push_vtx(8388607, 0, 8388607, 0);
        push_vtx(8388607, 0, 8388607, 0);
        push_vtx(-8388608, -1, 8388607, 1);

        // full capacity plus two dropped vertices
        set_normal(-3, 5, 32767);
        for (int i = 0; i < 66; i++)
            push_uv($rtoi(1048576.0 * $cos(6.283185307 * i / 66)),
                    $rtoi(1048576.0 * $sin(6.283185307 * i / 66)), i, i == 65);

        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            set_normal(pick_norm(), pick_norm(), pick_norm());
            if (phase == 4) begin
                // receiver holds off while two polygons queue up behind it
                send_idle_pct = 0;
                hold_req = 1'b1;
                for (int i = 0; i < 2; i++) star_polygon(4, 65536);
            end else begin
                random_polygon();
            end
        end

        wait_idle();
        $display("covered %0d polygons, %0d vertices, %0d triangles checked",
                 polys_queued, vtx_accepted, tri_checked);
        $display("fan triangles %0d, overflow triangles %0d", fan_seen, ovf_seen_cnt);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pect_pkg.sv
hw/rtl/pect_vtx_if.sv
hw/rtl/pect_tri_if.sv
hw/rtl/pect_datapath.sv
hw/rtl/pect_ctrl.sv
hw/rtl/polygon_ear_clip_triangulator_unit.sv
sim/tb_polygon_ear_clip_triangulator_unit.sv
